// ----- rtl/srb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Retry/backoff controller package
// Shared types, codes and constants for the upload sync retry controller.
// ----------------------------------------------------------------------------
package srb_pkg;

   // Request operation codes
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_TRIGGER = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;

   // Strategy codes
   localparam logic [1:0] STRAT_IMMEDIATE = 2'd0;
   localparam logic [1:0] STRAT_BATCH     = 2'd1;
   localparam logic [1:0] STRAT_SCHEDULED = 2'd2;

   // Reported mode codes
   localparam logic [1:0] CODE_IDLE = 2'd0;
   localparam logic [1:0] CODE_WAIT = 2'd1;
   localparam logic [1:0] CODE_SYNC = 2'd2;
   localparam logic [1:0] CODE_ERR  = 2'd3;

   // Register indexes (byte address = 4 * index)
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_ADDR_W = CSR_IDX_W + 2;
   localparam logic [CSR_IDX_W-1:0] REG_REMOTE_EN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_AUTO_EN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STRATEGY   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BATCH_SIZE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_DELAY = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DELAY  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RETRY  = 3'd7;

   // Fixed recheck interval and forced batch limit
   localparam logic [31:0] RECHECK_MS   = 32'd5000;
   localparam logic [9:0]  FORCED_LIMIT = 10'd1000;

   // Controller mode, one-hot
   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_WAIT = 4'b0010,
      MODE_SYNC = 4'b0100,
      MODE_ERR  = 4'b1000
   } mode_type;

   function automatic logic [1:0] mode_code(input mode_type m);
      logic [1:0] c;
      case (m)
         MODE_IDLE: c = CODE_IDLE;
         MODE_WAIT: c = CODE_WAIT;
         MODE_SYNC: c = CODE_SYNC;
         MODE_ERR:  c = CODE_ERR;
         default:   c = CODE_IDLE;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/srb_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one controller request.
// ----------------------------------------------------------------------------
interface srb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] now_ms;
   logic        wifi_connected;
   logic [15:0] pending_count;
   logic        force_all;
   logic        attempt_ok;
   logic        pending_after;

   modport source (
      output valid, op, now_ms, wifi_connected, pending_count, force_all,
             attempt_ok, pending_after,
      input  ready
   );
   modport sink (
      input  valid, op, now_ms, wifi_connected, pending_count, force_all,
             attempt_ok, pending_after,
      output ready
   );
endinterface

// ----- rtl/srb_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one controller result.
// ----------------------------------------------------------------------------
interface srb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic        attempted;
   logic [9:0]  batch_limit;
   logic        succeeded;
   logic        gave_up;
   logic [7:0]  retry_count;
   logic [31:0] retry_delay;

   modport source (
      output valid, mode, attempted, batch_limit, succeeded, gave_up,
             retry_count, retry_delay,
      input  ready
   );
   modport sink (
      input  valid, mode, attempted, batch_limit, succeeded, gave_up,
             retry_count, retry_delay,
      output ready
   );
endinterface

// ----- rtl/sync_retry_backoff_controller_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Upload sync retry controller with exponential backoff
// Decides when to attempt an upload and tracks retries, backoff and error.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one request per handshake: a tick (time, link, pending count and
//          the outcome of any attempt made on it), a manual trigger or a
//          retry reset.
//   rsp  : exactly one result per request, in order: mode after the step,
//          attempt flags, batch limit, retry count and current backoff.
//   APB  : eight 32-bit registers at byte address 4*index, write only while
//          the block is idle. pready is tied high; reads return the value.
// Timing:
//   A request is registered on accept and evaluated once the result register
//   is free, which writes the result register and raises rsp.valid. One
//   request per cycle is taken sustained while rsp is taken; the
//   controller state updates in the same cycle as the result.
// Reset:
//   Synchronous reset clears both pipeline registers and the controller
//   state (idle, no retries) and loads register defaults.
// Stall:
//   When rsp is not taken the result register holds and the input register
//   fills; req.ready drops only when both are occupied.
// ----------------------------------------------------------------------------
module sync_retry_backoff_controller_top (
   input  logic                           clock,
   input  logic                           reset,
   srb_req_if.sink                        req,
   srb_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [srb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   // Configuration registers
   logic        remote_en_ff;
   logic        auto_en_ff;
   logic [1:0]  strategy_ff;
   logic [9:0]  batch_size_ff;
   logic [31:0] interval_ff;
   logic [31:0] init_delay_ff;
   logic [31:0] max_delay_ff;
   logic [7:0]  max_retry_ff;

   // Controller state
   srb_pkg::mode_type mode_ff, mode_in;
   logic [7:0]  retries_ff, retries_in;
   logic [31:0] backoff_ff, backoff_in;
   logic [31:0] deadline_ff, deadline_in;
   logic [31:0] last_ok_ff, last_ok_in;
   logic        force_ff, force_in;
   logic        link_up_ff, link_up_in;

   // Input register
   logic        in_valid_ff;
   logic [1:0]  op_ff;
   logic [31:0] now_ff;
   logic        wifi_ff;
   logic [15:0] pending_ff;
   logic        force_all_ff;
   logic        ok_ff;
   logic        more_ff;

   // Result register
   logic        out_valid_ff;
   logic [1:0]  mode_out_ff;
   logic        attempted_ff, attempted_in;
   logic [9:0]  limit_ff, limit_in;
   logic        succeeded_ff, succeeded_in;
   logic        gave_up_ff, gave_up_in;
   logic [7:0]  retry_out_ff;
   logic [31:0] delay_out_ff;

   logic        advance;
   logic        csr_write;
   logic [srb_pkg::CSR_IDX_W-1:0] csr_idx;
   logic [7:0]  retries_inc;
   logic [63:0] shifted;
   logic [31:0] backoff_next;

   // Handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign pready    = 1'b1;
   assign csr_idx   = paddr[srb_pkg::CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         remote_en_ff  <= 1'b1;
         auto_en_ff    <= 1'b1;
         strategy_ff   <= srb_pkg::STRAT_IMMEDIATE;
         batch_size_ff <= 10'd10;
         interval_ff   <= 32'd60000;
         init_delay_ff <= 32'd1000;
         max_delay_ff  <= 32'd60000;
         max_retry_ff  <= 8'd5;
      end else if (csr_write) begin
         case (csr_idx)
            srb_pkg::REG_REMOTE_EN:  remote_en_ff  <= pwdata[0];
            srb_pkg::REG_AUTO_EN:    auto_en_ff    <= pwdata[0];
            srb_pkg::REG_STRATEGY:   strategy_ff   <= pwdata[1:0];
            srb_pkg::REG_BATCH_SIZE: batch_size_ff <= pwdata[9:0];
            srb_pkg::REG_INTERVAL:   interval_ff   <= pwdata;
            srb_pkg::REG_INIT_DELAY: init_delay_ff <= pwdata;
            srb_pkg::REG_MAX_DELAY:  max_delay_ff  <= pwdata;
            srb_pkg::REG_MAX_RETRY:  max_retry_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      case (csr_idx)
         srb_pkg::REG_REMOTE_EN:  prdata = {31'd0, remote_en_ff};
         srb_pkg::REG_AUTO_EN:    prdata = {31'd0, auto_en_ff};
         srb_pkg::REG_STRATEGY:   prdata = {30'd0, strategy_ff};
         srb_pkg::REG_BATCH_SIZE: prdata = {22'd0, batch_size_ff};
         srb_pkg::REG_INTERVAL:   prdata = interval_ff;
         srb_pkg::REG_INIT_DELAY: prdata = init_delay_ff;
         srb_pkg::REG_MAX_DELAY:  prdata = max_delay_ff;
         srb_pkg::REG_MAX_RETRY:  prdata = {24'd0, max_retry_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         op_ff        <= req.op;
         now_ff       <= req.now_ms;
         wifi_ff      <= req.wifi_connected;
         pending_ff   <= req.pending_count;
         force_all_ff <= req.force_all;
         ok_ff        <= req.attempt_ok;
         more_ff      <= req.pending_after;
      end
   end

   // Backoff for the next failure: saturating count, shift and cap
   assign retries_inc = (retries_ff == 8'hFF) ? retries_ff : retries_ff + 8'd1;
   assign shifted     = {32'd0, init_delay_ff} << retries_inc[4:0];

   always_comb begin
      if (init_delay_ff == 32'd0) begin
         backoff_next = 32'd0;
      end else if (retries_inc[7:5] != 3'd0) begin
         backoff_next = max_delay_ff;
      end else if (shifted > {32'd0, max_delay_ff}) begin
         backoff_next = max_delay_ff;
      end else begin
         backoff_next = shifted[31:0];
      end
   end

   // Step logic
   always_comb begin
      mode_in      = mode_ff;
      retries_in   = retries_ff;
      backoff_in   = backoff_ff;
      deadline_in  = deadline_ff;
      last_ok_in   = last_ok_ff;
      force_in     = force_ff;
      link_up_in   = link_up_ff;
      attempted_in = 1'b0;
      limit_in     = 10'd0;
      succeeded_in = 1'b0;
      gave_up_in   = 1'b0;

      case (op_ff)
         srb_pkg::OP_TRIGGER: begin
            force_in = force_all_ff;
            mode_in  = srb_pkg::MODE_SYNC;
         end
         srb_pkg::OP_CLEAR: begin
            retries_in  = 8'd0;
            backoff_in  = 32'd0;
            deadline_in = 32'd0;
            if (mode_ff == srb_pkg::MODE_ERR || mode_ff == srb_pkg::MODE_WAIT) begin
               mode_in = srb_pkg::MODE_IDLE;
            end
         end
         srb_pkg::OP_TICK: begin
            if (remote_en_ff) begin
               // link came up with data waiting
               if (wifi_ff && !link_up_ff && auto_en_ff && pending_ff != 16'd0) begin
                  force_in = 1'b0;
                  mode_in  = srb_pkg::MODE_SYNC;
               end
               link_up_in = wifi_ff;

               case (mode_in)
                  srb_pkg::MODE_IDLE: begin
                     if (pending_ff != 16'd0 && wifi_ff) begin
                        case (strategy_ff)
                           srb_pkg::STRAT_IMMEDIATE: mode_in = srb_pkg::MODE_SYNC;
                           srb_pkg::STRAT_BATCH: begin
                              if (pending_ff >= {6'd0, batch_size_ff}) begin
                                 mode_in = srb_pkg::MODE_SYNC;
                              end
                           end
                           srb_pkg::STRAT_SCHEDULED: begin
                              if ((now_ff - last_ok_ff) >= interval_ff) begin
                                 mode_in = srb_pkg::MODE_SYNC;
                              end
                           end
                           default: ;
                        endcase
                     end
                  end
                  srb_pkg::MODE_WAIT: begin
                     if (now_ff >= deadline_ff) begin
                        if (wifi_ff) begin
                           mode_in = srb_pkg::MODE_SYNC;
                        end else begin
                           deadline_in = now_ff + srb_pkg::RECHECK_MS;
                        end
                     end
                  end
                  srb_pkg::MODE_SYNC: begin
                     if (wifi_ff) begin
                        attempted_in = 1'b1;
                        limit_in     = force_in ? srb_pkg::FORCED_LIMIT : batch_size_ff;
                        // nothing pending counts as success and keeps the force flag
                        if (pending_ff == 16'd0) begin
                           succeeded_in = 1'b1;
                        end else begin
                           succeeded_in = ok_ff;
                           force_in     = 1'b0;
                        end
                        if (succeeded_in) begin
                           retries_in = 8'd0;
                           backoff_in = 32'd0;
                           last_ok_in = now_ff;
                           if (!(more_ff && pending_ff != 16'd0)) begin
                              mode_in = srb_pkg::MODE_IDLE;
                           end
                        end else begin
                           retries_in  = retries_inc;
                           backoff_in  = backoff_next;
                           deadline_in = now_ff + backoff_next;
                           if (retries_inc >= max_retry_ff) begin
                              mode_in    = srb_pkg::MODE_ERR;
                              gave_up_in = 1'b1;
                           end else begin
                              mode_in = srb_pkg::MODE_WAIT;
                           end
                        end
                     end else begin
                        mode_in     = srb_pkg::MODE_WAIT;
                        deadline_in = now_ff + srb_pkg::RECHECK_MS;
                     end
                  end
                  default: begin
                     if (now_ff >= deadline_ff) begin
                        mode_in = (wifi_ff && pending_ff != 16'd0) ? srb_pkg::MODE_SYNC
                                                                  : srb_pkg::MODE_IDLE;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   // Controller state update
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= srb_pkg::MODE_IDLE;
         retries_ff  <= 8'd0;
         backoff_ff  <= 32'd0;
         deadline_ff <= 32'd0;
         last_ok_ff  <= 32'd0;
         force_ff    <= 1'b0;
         link_up_ff  <= 1'b0;
      end else if (advance) begin
         mode_ff     <= mode_in;
         retries_ff  <= retries_in;
         backoff_ff  <= backoff_in;
         deadline_ff <= deadline_in;
         last_ok_ff  <= last_ok_in;
         force_ff    <= force_in;
         link_up_ff  <= link_up_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mode_out_ff  <= srb_pkg::mode_code(mode_in);
         attempted_ff <= attempted_in;
         limit_ff     <= limit_in;
         succeeded_ff <= succeeded_in;
         gave_up_ff   <= gave_up_in;
         retry_out_ff <= retries_in;
         delay_out_ff <= backoff_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.mode        = mode_out_ff;
   assign rsp.attempted   = attempted_ff;
   assign rsp.batch_limit = limit_ff;
   assign rsp.succeeded   = succeeded_ff;
   assign rsp.gave_up     = gave_up_ff;
   assign rsp.retry_count = retry_out_ff;
   assign rsp.retry_delay = delay_out_ff;

endmodule

// ----- verif/srb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Retry controller scoreboard
// Watches the request, result and register ports of the upload sync retry
// controller. It keeps its own copy of the registers and controller state,
// predicts the result of every accepted request, and compares each accepted
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module srb_checker (
   input  logic                           clock,
   input  logic                           reset,
   srb_req_if                             req,
   srb_rsp_if                             rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [srb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   input  logic                           pready,
   output int unsigned                    fail_count,
   output int unsigned                    results_due
);

   typedef struct packed {
      logic [1:0]  mode;
      logic        attempted;
      logic [9:0]  batch_limit;
      logic        succeeded;
      logic        gave_up;
      logic [7:0]  retry_count;
      logic [31:0] retry_delay;
   } sync_outcome_type;

   // Register shadow
   logic        sync_on;
   logic        auto_on;
   logic [1:0]  strategy_sel;
   logic [9:0]  batch_size;
   logic [31:0] interval_ms;
   logic [31:0] base_delay;
   logic [31:0] delay_cap;
   logic [7:0]  retry_limit;

   // Controller state
   logic [1:0]  cur_mode;
   logic [7:0]  retries;
   logic [31:0] backoff;
   logic [31:0] deadline;
   logic [31:0] last_ok_ms;
   logic        forced;
   logic        link_up;

   // Outcomes predicted for requests whose result has not come back yet
   sync_outcome_type awaited_outcomes[$];

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      sync_outcome_type predicted;
      sync_outcome_type seen;
      logic             go;
      logic [31:0]      elapsed;
      logic [63:0]      wide;
      if (reset) begin
         sync_on      = 1'b1;
         auto_on      = 1'b1;
         strategy_sel = srb_pkg::STRAT_IMMEDIATE;
         batch_size   = 10'd10;
         interval_ms  = 32'd60000;
         base_delay   = 32'd1000;
         delay_cap    = 32'd60000;
         retry_limit  = 8'd5;
         cur_mode     = srb_pkg::CODE_IDLE;
         retries      = '0;
         backoff      = '0;
         deadline     = '0;
         last_ok_ms   = '0;
         forced       = 1'b0;
         link_up      = 1'b0;
         fail_count   = 0;
         awaited_outcomes.delete();
      end else begin
         // Register writes land on the access cycle
         if (psel && penable && pwrite && pready) begin
            case (paddr[srb_pkg::CSR_ADDR_W-1:2])
               srb_pkg::REG_REMOTE_EN:  sync_on      = pwdata[0];
               srb_pkg::REG_AUTO_EN:    auto_on      = pwdata[0];
               srb_pkg::REG_STRATEGY:   strategy_sel = pwdata[1:0];
               srb_pkg::REG_BATCH_SIZE: batch_size   = pwdata[9:0];
               srb_pkg::REG_INTERVAL:   interval_ms  = pwdata;
               srb_pkg::REG_INIT_DELAY: base_delay   = pwdata;
               srb_pkg::REG_MAX_DELAY:  delay_cap    = pwdata;
               srb_pkg::REG_MAX_RETRY:  retry_limit  = pwdata[7:0];
               default: ;
            endcase
         end

         // Predict the outcome of an accepted request
         if (req.valid && req.ready) begin
            predicted = '0;
            go = 1'b0;
            case (req.op)
               srb_pkg::OP_TRIGGER: begin
                  forced   = req.force_all;
                  cur_mode = srb_pkg::CODE_SYNC;
               end
               srb_pkg::OP_CLEAR: begin
                  retries  = '0;
                  backoff  = '0;
                  deadline = '0;
                  if (cur_mode == srb_pkg::CODE_ERR || cur_mode == srb_pkg::CODE_WAIT)
                     cur_mode = srb_pkg::CODE_IDLE;
               end
               srb_pkg::OP_TICK: if (sync_on) begin
                  // link coming up with data waiting kicks off a sync
                  if (req.wifi_connected && !link_up && auto_on && req.pending_count != 0) begin
                     forced   = 1'b0;
                     cur_mode = srb_pkg::CODE_SYNC;
                  end
                  link_up = req.wifi_connected;
                  case (cur_mode)
                     srb_pkg::CODE_IDLE: begin
                        if (req.pending_count != 0 && req.wifi_connected) begin
                           elapsed = req.now_ms - last_ok_ms;
                           case (strategy_sel)
                              srb_pkg::STRAT_IMMEDIATE: go = 1'b1;
                              srb_pkg::STRAT_BATCH:
                                 go = (req.pending_count >= {6'd0, batch_size});
                              srb_pkg::STRAT_SCHEDULED: go = (elapsed >= interval_ms);
                              default:                  go = 1'b0;
                           endcase
                        end
                        if (go) cur_mode = srb_pkg::CODE_SYNC;
                     end
                     srb_pkg::CODE_WAIT: begin
                        if (req.now_ms >= deadline) begin
                           if (req.wifi_connected) cur_mode = srb_pkg::CODE_SYNC;
                           else deadline = req.now_ms + srb_pkg::RECHECK_MS;
                        end
                     end
                     srb_pkg::CODE_SYNC: begin
                        if (req.wifi_connected) begin
                           predicted.attempted   = 1'b1;
                           predicted.batch_limit = forced ? srb_pkg::FORCED_LIMIT : batch_size;
                           // nothing to send counts as success and keeps the force flag
                           if (req.pending_count == 0) begin
                              predicted.succeeded = 1'b1;
                           end else begin
                              predicted.succeeded = req.attempt_ok;
                              forced = 1'b0;
                           end
                           if (predicted.succeeded) begin
                              retries    = '0;
                              backoff    = '0;
                              last_ok_ms = req.now_ms;
                              if (!(req.pending_after && req.pending_count != 0))
                                 cur_mode = srb_pkg::CODE_IDLE;
                           end else begin
                              if (retries != 8'hFF) retries = retries + 8'd1;
                              // exponential backoff, saturating at the cap
                              wide = {32'd0, base_delay} << retries;
                              if (base_delay == 0) backoff = '0;
                              else if (retries >= 8'd32) backoff = delay_cap;
                              else if (wide > {32'd0, delay_cap}) backoff = delay_cap;
                              else backoff = wide[31:0];
                              deadline = req.now_ms + backoff;
                              if (retries >= retry_limit) begin
                                 cur_mode = srb_pkg::CODE_ERR;
                                 predicted.gave_up = 1'b1;
                              end else begin
                                 cur_mode = srb_pkg::CODE_WAIT;
                              end
                           end
                        end else begin
                           cur_mode = srb_pkg::CODE_WAIT;
                           deadline = req.now_ms + srb_pkg::RECHECK_MS;
                        end
                     end
                     default: begin
                        if (req.now_ms >= deadline)
                           cur_mode = (req.wifi_connected && req.pending_count != 0) ?
                                      srb_pkg::CODE_SYNC : srb_pkg::CODE_IDLE;
                     end
                  endcase
               end
               default: ;
            endcase
            predicted.mode        = cur_mode;
            predicted.retry_count = retries;
            predicted.retry_delay = backoff;
            awaited_outcomes.push_back(predicted);
         end

         // Compare an accepted result with the oldest prediction
         if (rsp.valid && rsp.ready) begin
            if (awaited_outcomes.size() == 0) begin
               $error("result with no request outstanding: mode %0d", rsp.mode);
               fail_count++;
            end else begin
               seen = awaited_outcomes.pop_front();
               check_field("mode", 32'(seen.mode), 32'(rsp.mode));
               check_field("attempted", 32'(seen.attempted), 32'(rsp.attempted));
               check_field("batch_limit", 32'(seen.batch_limit), 32'(rsp.batch_limit));
               check_field("succeeded", 32'(seen.succeeded), 32'(rsp.succeeded));
               check_field("gave_up", 32'(seen.gave_up), 32'(rsp.gave_up));
               check_field("retry_count", 32'(seen.retry_count), 32'(rsp.retry_count));
               check_field("retry_delay", seen.retry_delay, rsp.retry_delay);
            end
         end
      end
      results_due <= awaited_outcomes.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Retry controller testbench
// Drives requests and register settings into the upload sync retry
// controller: a short directed sequence through every operation and corner,
// then random traffic over several register settings, including a failure
// storm that drives the retry count to saturation. Results are checked by
// the scoreboard; the sender runs in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam logic [1:0]  OP_UNDEFINED = 2'd3;
   localparam logic [1:0]  STRAT_MANUAL = 2'd3;
   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 10;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [srb_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]                    pwdata = '0;
   logic [31:0]                    prdata;
   logic                           pready;

   int unsigned fail_count;
   int unsigned results_due;
   int unsigned burst_left = 8;
   logic        hold_armed = 1'b0;
   logic [31:0] clock_ms = '0;

   srb_req_if req ();
   srb_rsp_if rsp ();

   always #5 clock = ~clock;

   sync_retry_backoff_controller_top dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .rsp     (rsp),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   srb_checker watcher (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   // Offer one request and hold it until accepted; idle between bursts
   task automatic offer_request(input logic [1:0] op, input logic [31:0] now,
                                input logic wifi, input logic [15:0] pending,
                                input logic force_all, input logic ok, input logic more);
      int unsigned gap;
      req.valid          <= 1'b1;
      req.op             <= op;
      req.now_ms         <= now;
      req.wifi_connected <= wifi;
      req.pending_count  <= pending;
      req.force_all      <= force_all;
      req.attempt_ok     <= ok;
      req.pending_after  <= more;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = $urandom_range(1, 12);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait for every outstanding result
   task automatic drain_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [srb_pkg::CSR_IDX_W-1:0] idx,
                            input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   // Load all eight registers; only called with the block drained
   task automatic configure(input logic [31:0] remote, input logic [31:0] auto_sync,
                            input logic [31:0] strat, input logic [31:0] batch,
                            input logic [31:0] interval, input logic [31:0] init_delay,
                            input logic [31:0] max_delay, input logic [31:0] max_retry);
      csr_write(srb_pkg::REG_REMOTE_EN, remote);
      csr_write(srb_pkg::REG_AUTO_EN, auto_sync);
      csr_write(srb_pkg::REG_STRATEGY, strat);
      csr_write(srb_pkg::REG_BATCH_SIZE, batch);
      csr_write(srb_pkg::REG_INTERVAL, interval);
      csr_write(srb_pkg::REG_INIT_DELAY, init_delay);
      csr_write(srb_pkg::REG_MAX_DELAY, max_delay);
      csr_write(srb_pkg::REG_MAX_RETRY, max_retry);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Random requests; rates in percent (ok) or per mille (the rest)
   task automatic run_traffic(input int unsigned count, input int unsigned ok_pct,
                              input int unsigned clear_pm, input int unsigned trig_pm,
                              input int unsigned wifi_pm, input int unsigned zero_pm,
                              input int unsigned max_step, input bit wild);
      int unsigned k;
      logic [1:0]  op;
      logic [15:0] pending;
      repeat (count) begin
         k = $urandom_range(0, 999);
         if (k < clear_pm) op = srb_pkg::OP_CLEAR;
         else if (k < clear_pm + trig_pm) op = srb_pkg::OP_TRIGGER;
         else if (k < clear_pm + trig_pm + 5) op = OP_UNDEFINED;
         else op = srb_pkg::OP_TICK;
         // time mostly creeps forward; wild phases also jump anywhere
         if (wild && $urandom_range(0, 9) == 0) clock_ms = $urandom;
         else clock_ms = clock_ms + $urandom_range(0, max_step);
         k = $urandom_range(0, 999);
         if (k < zero_pm) pending = '0;
         else if (k < zero_pm + 100) pending = 16'($urandom);
         else pending = 16'($urandom_range(1, 1100));
         offer_request(op, clock_ms, $urandom_range(0, 999) < wifi_pm, pending,
                       1'($urandom_range(0, 1)), $urandom_range(0, 99) < ok_pct,
                       1'($urandom_range(0, 1)));
      end
   endtask

   // Result side: stall pattern changes every window, one long hold-off
   initial begin
      int unsigned window;
      int unsigned style;
      int unsigned beat;
      bit          hold_done;
      window = 0;
      style = 0;
      beat = 0;
      hold_done = 1'b0;
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (window == 0) begin
               style = $urandom_range(0, 3);
               window = $urandom_range(16, 96);
            end
            window--;
            beat++;
            case (style)
               0: rsp.ready <= 1'b1;
               1: rsp.ready <= 1'($urandom_range(0, 1));
               2: rsp.ready <= (beat % 3 == 0);
               default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Watchdog: too long without any handshake ends the run
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || (psel && penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL sync_retry_backoff_controller_top");
      $finish;
   end

   initial begin
      req.valid = 1'b0;
      req.op = srb_pkg::OP_TICK;
      req.now_ms = '0;
      req.wifi_connected = 1'b0;
      req.pending_count = '0;
      req.force_all = 1'b0;
      req.attempt_ok = 1'b0;
      req.pending_after = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset register values: fail, back off, recheck, force flag
      offer_request(srb_pkg::OP_TICK, 32'd0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_TICK, 32'd100, 1'b1, 16'd5, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_TICK, 32'd200, 1'b1, 16'd5, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_TICK, 32'd3000, 1'b0, 16'd5, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_TICK, 32'd8000, 1'b1, 16'd5, 1'b0, 1'b0, 1'b0);
      offer_request(OP_UNDEFINED, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1);
      offer_request(srb_pkg::OP_TRIGGER, 32'd0, 1'b0, 16'd0, 1'b1, 1'b0, 1'b0);
      // empty attempt succeeds and keeps the force flag
      offer_request(srb_pkg::OP_TICK, 32'd12000, 1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_TICK, 32'd12001, 1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b1);
      offer_request(srb_pkg::OP_TICK, 32'd12002, 1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b1);
      offer_request(srb_pkg::OP_TICK, 32'd12003, 1'b1, 16'd7, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_CLEAR, 32'd0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
      // deadlines across the time wrap
      offer_request(srb_pkg::OP_TICK, 32'hFFFF_F000, 1'b1, 16'd3, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_TICK, 32'hFFFF_FC00, 1'b1, 16'd3, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b1, 16'd3, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_TICK, 32'hFFFF_FFFF, 1'b0, 16'd3, 1'b0, 1'b0, 1'b0);
      drain_results();

      // Directed: zero batch size, zero retry limit, backoff past the cap
      configure(1, 0, 32'(srb_pkg::STRAT_BATCH), 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0);
      offer_request(srb_pkg::OP_CLEAR, 32'd0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_TICK, 32'd500, 1'b1, 16'd1, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_TICK, 32'd600, 1'b1, 16'd1, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_TICK, 32'd700, 1'b1, 16'd1, 1'b0, 1'b1, 1'b0);
      offer_request(srb_pkg::OP_TICK, 32'd800, 1'b1, 16'd1, 1'b0, 1'b1, 1'b1);
      drain_results();

      // Directed: sync disabled, only trigger and clear act
      configure(0, 1, 32'(STRAT_MANUAL), 1000, 0, 0, 0, 255);
      offer_request(srb_pkg::OP_TICK, 32'd900, 1'b1, 16'd9, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_TRIGGER, 32'd0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
      offer_request(srb_pkg::OP_CLEAR, 32'd0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
      offer_request(OP_UNDEFINED, 32'd0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0);
      drain_results();

      // Random traffic over several register settings
      configure(1, 1, 32'(srb_pkg::STRAT_IMMEDIATE), 10, 60000, 1000, 60000, 5);
      clock_ms = 32'd20000;
      hold_armed <= 1'b1;
      run_traffic(150, 60, 20, 40, 850, 100, 3000, 1'b0);
      drain_results();

      configure(1, 1, 32'(srb_pkg::STRAT_BATCH), 1000, 60000, 0, 60000, 1);
      run_traffic(150, 50, 20, 30, 800, 100, 3000, 1'b0);
      drain_results();

      configure(1, 0, 32'(srb_pkg::STRAT_SCHEDULED), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 255);
      clock_ms = 32'hFFFF_0000;
      run_traffic(150, 40, 10, 60, 850, 100, 20000, 1'b1);
      drain_results();

      configure(1, 1, 32'(srb_pkg::STRAT_SCHEDULED), $urandom_range(1, 1000),
                $urandom_range(0, 100000), $urandom_range(1, 5000),
                $urandom_range(0, 200000), $urandom_range(1, 255));
      run_traffic(150, 50, 15, 20, 850, 100, 30000, 1'b0);
      drain_results();

      configure(1, 1, 32'(STRAT_MANUAL), 1, 0, 1, 0, 0);
      run_traffic(150, 50, 20, 80, 850, 100, 3000, 1'b0);
      drain_results();

      configure(0, 0, 32'(srb_pkg::STRAT_IMMEDIATE), 10, 60000, 1000, 60000, 5);
      run_traffic(80, 50, 20, 40, 500, 100, 3000, 1'b1);
      drain_results();

      // Failure storm: nothing ever succeeds, retry count climbs to its ceiling
      configure(1, 1, 32'(srb_pkg::STRAT_IMMEDIATE), $urandom_range(1, 1000), 0, 1, 100, 3);
      clock_ms = '0;
      run_traffic(700, 0, 0, 5, 998, 0, 400, 1'b0);
      drain_results();

      configure($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 3),
                $urandom_range(0, 1023), $urandom, $urandom, $urandom, $urandom_range(0, 255));
      run_traffic(150, 50, 15, 30, 850, 100, 5000, 1'b1);
      drain_results();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && results_due == 0) begin
         $display("PASS sync_retry_backoff_controller_top");
      end else begin
         $display("FAIL sync_retry_backoff_controller_top");
      end
      $finish;
   end

endmodule
